[hdl/jse_pkg.sv]
`timescale 1ns / 1ps
// jse_pkg: item types, character codes and the hex digit helper
// for the json string escaper; no dependencies

package jse_pkg;

    localparam int RunMax  = 6;
    localparam int RunLenW = 3;

    // input item
    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_string;
    } jse_in_t;

    // result item
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       error;
        logic       run_last;
        logic       string_end;
    } jse_out_t;

    // escaped run for one input byte, bytes[0] goes out first
    typedef struct packed {
        logic [RunMax-1:0][7:0] bytes;
        logic [RunLenW-1:0]     len;
        logic                   byte_valid;
        logic                   error;
        logic                   eos;
    } jse_run_t;

    // raw byte codes with short escapes, and DEL
    localparam logic [7:0] CHR_BACKSPACE = 8'h08;
    localparam logic [7:0] CHR_TAB       = 8'h09;
    localparam logic [7:0] CHR_LF        = 8'h0A;
    localparam logic [7:0] CHR_CR        = 8'h0D;
    localparam logic [7:0] CHR_QUOTE     = 8'h22;
    localparam logic [7:0] CHR_BSLASH    = 8'h5C;
    localparam logic [7:0] CHR_DEL       = 8'h7F;

    // escape letters and digits
    localparam logic [7:0] CHR_LET_B  = 8'h62;
    localparam logic [7:0] CHR_LET_T  = 8'h74;
    localparam logic [7:0] CHR_LET_N  = 8'h6E;
    localparam logic [7:0] CHR_LET_R  = 8'h72;
    localparam logic [7:0] CHR_LET_U  = 8'h75;
    localparam logic [7:0] CHR_ZERO   = 8'h30;
    localparam logic [7:0] HEX_ALPHA  = 8'h37;   // 'A' - 10
    localparam logic [3:0] HEX_TEN    = 4'hA;

    // byte class boundaries
    localparam logic [7:0] CTRL_END   = 8'h20;
    localparam logic [7:0] ASCII_END  = 8'h80;
    localparam logic [7:0] LEAD_MIN   = 8'hC0;
    localparam logic [7:0] LEAD3_MIN  = 8'hE0;
    localparam logic [7:0] LEAD4_MIN  = 8'hF0;
    localparam logic [7:0] LEAD_MAX   = 8'hF4;

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] nib_w;
        nib_w = {4'h0, nib};
        return (nib < HEX_TEN) ? (CHR_ZERO + nib_w) : (HEX_ALPHA + nib_w);
    endfunction

endpackage

[hdl/json_string_escape.sv]
`timescale 1ns / 1ps
// json_string_escape: input register, escape logic and run output register
// an item's first result is valid once its run is loaded from the input to the output register
// throughput: one item per cycle while m_ready is high and runs are one byte; a run of n bytes
// goes out one byte per handshake, and the output register loads no new run until its last byte
// reset: synchronous active-low aresetn empties both registers and clears
// the utf-8 pending count and the error flag

module json_string_escape
    import jse_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  jse_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output jse_out_t m_data
);

    logic     in_valid_reg;
    jse_in_t  in_reg;
    jse_run_t run;
    logic     can_load;
    logic     load;

    assign load    = in_valid_reg && can_load;
    assign s_ready = !in_valid_reg || can_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (load) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    jse_escape u_escape (
        .aclk    (aclk),
        .aresetn (aresetn),
        .item    (in_reg),
        .commit  (load),
        .run     (run)
    );

    jse_run_out u_run_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (load),
        .run      (run),
        .can_load (can_load),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

[hdl/jse_escape.sv]
`timescale 1ns / 1ps
// jse_escape: classifies one raw byte and builds its escaped run,
// holds the per-string utf-8 and error state; uses jse_pkg

module jse_escape
    import jse_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  jse_in_t  item,
    input  logic     commit,
    output jse_run_t run
);

    logic [1:0] pending_raw_reg, pending_raw_next;
    logic       error_latched_reg, error_latched_next;
    logic [7:0] b;
    logic [7:0] letter;
    logic       is_short;

    assign b = item.in_byte;

    always_comb begin
        is_short = 1'b1;
        letter   = b;
        case (b)
            CHR_BACKSPACE: letter = CHR_LET_B;
            CHR_TAB:       letter = CHR_LET_T;
            CHR_LF:        letter = CHR_LET_N;
            CHR_CR:        letter = CHR_LET_R;
            CHR_QUOTE:     letter = b;
            CHR_BSLASH:    letter = b;
            default:       is_short = 1'b0;
        endcase
    end

    always_comb begin
        run                = '0;
        run.len            = RunLenW'(1);
        run.byte_valid     = 1'b1;
        run.eos            = item.end_of_string;
        pending_raw_next   = pending_raw_reg;
        error_latched_next = error_latched_reg;

        if (error_latched_reg) begin
            run.byte_valid = 1'b0;
            run.error      = 1'b1;
        end else if (pending_raw_reg != 2'd0) begin
            // continuation bytes are copied unchecked
            run.bytes[0]     = b;
            pending_raw_next = pending_raw_reg - 2'd1;
        end else if (is_short) begin
            run.bytes[0] = CHR_BSLASH;
            run.bytes[1] = letter;
            run.len      = RunLenW'(2);
        end else if (b < CTRL_END || b == CHR_DEL) begin
            run.bytes[0] = CHR_BSLASH;
            run.bytes[1] = CHR_LET_U;
            run.bytes[2] = CHR_ZERO;
            run.bytes[3] = CHR_ZERO;
            run.bytes[4] = hex_digit(b[7:4]);
            run.bytes[5] = hex_digit(b[3:0]);
            run.len      = RunLenW'(RunMax);
        end else if (b < ASCII_END) begin
            run.bytes[0] = b;
        end else if (b >= LEAD_MIN && b <= LEAD_MAX) begin
            run.bytes[0] = b;
            if (b < LEAD3_MIN) begin
                pending_raw_next = 2'd1;
            end else if (b < LEAD4_MIN) begin
                pending_raw_next = 2'd2;
            end else begin
                pending_raw_next = 2'd3;
            end
        end else begin
            // stray continuation or never-valid byte
            run.byte_valid     = 1'b0;
            run.error          = 1'b1;
            error_latched_next = 1'b1;
            pending_raw_next   = 2'd0;
        end

        if (item.end_of_string) begin
            pending_raw_next   = 2'd0;
            error_latched_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_raw_reg   <= 2'd0;
            error_latched_reg <= 1'b0;
        end else if (commit) begin
            pending_raw_reg   <= pending_raw_next;
            error_latched_reg <= error_latched_next;
        end
    end

endmodule

[hdl/jse_run_out.sv]
`timescale 1ns / 1ps
// jse_run_out: result register that holds one escaped run and
// shifts it out one byte per handshake; uses jse_pkg

module jse_run_out
    import jse_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     load,
    input  jse_run_t run,
    output logic     can_load,
    output logic     m_valid,
    input  logic     m_ready,
    output jse_out_t m_data
);

    logic                   run_valid_reg;
    logic [RunLenW-1:0]     rem_reg;
    logic [RunMax-1:0][7:0] bytes_reg;
    logic                   byte_valid_reg;
    logic                   error_reg;
    logic                   eos_reg;
    logic                   at_last;

    assign at_last  = (rem_reg == RunLenW'(1));
    assign can_load = !run_valid_reg || (m_ready && at_last);

    assign m_valid           = run_valid_reg;
    assign m_data.out_byte   = bytes_reg[0];
    assign m_data.byte_valid = byte_valid_reg;
    assign m_data.error      = error_reg;
    assign m_data.run_last   = at_last;
    assign m_data.string_end = at_last && eos_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_valid_reg <= 1'b0;
        end else if (load) begin
            run_valid_reg <= 1'b1;
        end else if (m_ready && at_last) begin
            run_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            bytes_reg      <= run.bytes;
            rem_reg        <= run.len;
            byte_valid_reg <= run.byte_valid;
            error_reg      <= run.error;
            eos_reg        <= run.eos;
        end else if (run_valid_reg && m_ready) begin
            bytes_reg <= {8'h00, bytes_reg[RunMax-1:1]};
            rem_reg   <= rem_reg - RunLenW'(1);
        end
    end

endmodule
